### design/shd_pkg.sv
// shared types, constants and calendar functions for the solar hijri day difference block
// no dependencies

package shd_pkg;

  localparam int YEAR_BITS_DEF = 12;
  localparam int YEAR_MAX_BITS = 16;
  localparam int DAY_BITS      = 5;
  localparam int MONTH_BITS    = 4;
  localparam int RES_BITS      = 6;
  localparam int COUNT_BITS    = 21;
  localparam int ORDER_BITS    = 2;

  localparam logic [RES_BITS-1:0]   RES_LAST  = RES_BITS'(32);
  localparam logic [MONTH_BITS-1:0] MONTH_LAST = MONTH_BITS'(12);

  localparam logic [ORDER_BITS-1:0] ORD_EQUAL         = 2'd0;
  localparam logic [ORDER_BITS-1:0] ORD_FIRST_LATER   = 2'd1;
  localparam logic [ORDER_BITS-1:0] ORD_FIRST_EARLIER = 2'd2;

  typedef logic [DAY_BITS-1:0]   day_t;
  typedef logic [MONTH_BITS-1:0] month_t;
  typedef logic [RES_BITS-1:0]   res_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // year mod 33, using 32 = -1 mod 33 on 5-bit chunks
  function automatic res_t year_mod33(input logic [YEAR_MAX_BITS-1:0] y);
    logic [7:0] s;
    s = 8'(y[4:0]) + 8'(y[14:10]) + 8'd66 - 8'(y[9:5]) - 8'(y[15]);
    if (s >= 8'd66) s = s - 8'd66;
    if (s >= 8'd33) s = s - 8'd33;
    return res_t'(s);
  endfunction

  function automatic logic is_leap(input res_t r);
    return (r == 6'd1) || (r == 6'd5) || (r == 6'd9) || (r == 6'd13) ||
           (r == 6'd17) || (r == 6'd22) || (r == 6'd26) || (r == 6'd30);
  endfunction

  function automatic day_t month_len(input month_t m, input logic leap);
    day_t len;
    if (m < 4'd7) len = 5'd31;
    else if (m < 4'd12) len = 5'd30;
    else len = leap ? 5'd30 : 5'd29;
    return len;
  endfunction

  function automatic logic date_ok(input day_t d, input month_t m, input res_t r);
    return (m >= 4'd1) && (m <= MONTH_LAST) && (d >= 5'd1) &&
           (d <= month_len(m, is_leap(r)));
  endfunction

endpackage

### design/shd_step.sv
// one-day increment unit shared by every step of the date walk
// depends on shd_pkg

module shd_step import shd_pkg::*; #(
  parameter int YEAR_BITS = YEAR_BITS_DEF
) (
  input  day_t                 cur_day,
  input  month_t               cur_month,
  input  logic [YEAR_BITS-1:0] cur_year,
  input  res_t                 cur_res,
  output day_t                 nxt_day,
  output month_t               nxt_month,
  output logic [YEAR_BITS-1:0] nxt_year,
  output res_t                 nxt_res
);

  logic month_end;

  assign month_end = (cur_day == month_len(cur_month, is_leap(cur_res)));

  always_comb begin
    nxt_day   = cur_day + 5'd1;
    nxt_month = cur_month;
    nxt_year  = cur_year;
    nxt_res   = cur_res;
    if (month_end) begin
      nxt_day = 5'd1;
      if (cur_month == MONTH_LAST) begin
        nxt_month = 4'd1;
        nxt_year  = cur_year + YEAR_BITS'(1);
        nxt_res   = (cur_res == RES_LAST) ? '0 : cur_res + 6'd1;
      end else begin
        nxt_month = cur_month + 4'd1;
      end
    end
  end

endmodule

### design/solar_hijri_day_difference_top.sv
// solar hijri day difference: validates two dates, then walks the earlier one day by day
// depends on shd_pkg and shd_step
// equal or invalid dates are answered from the check state with no walk; otherwise the walk
// advances one day per cycle in shd_step; one item at a time, busy high until the result
// strobe cycle
// reset: rst_n synchronous active low, returns to idle with no strobe; receiver cannot stall

module solar_hijri_day_difference_top import shd_pkg::*; #(
  parameter int YEAR_BITS = YEAR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  day_t                  in_first_day,
  input  month_t                in_first_month,
  input  logic [YEAR_BITS-1:0]  in_first_year,
  input  day_t                  in_second_day,
  input  month_t                in_second_month,
  input  logic [YEAR_BITS-1:0]  in_second_year,
  output logic                  out_valid,
  output count_t                out_day_count,
  output logic [ORDER_BITS-1:0] out_order,
  output logic                  out_date_error
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;

  logic [1:0] state_r, state_nxt;

  day_t                 d1_r, d2_r;
  month_t               m1_r, m2_r;
  logic [YEAR_BITS-1:0] y1_r, y2_r;

  day_t                 cur_d_r, cur_d_nxt, tgt_d_r, tgt_d_nxt;
  month_t               cur_m_r, cur_m_nxt, tgt_m_r, tgt_m_nxt;
  logic [YEAR_BITS-1:0] cur_y_r, cur_y_nxt, tgt_y_r, tgt_y_nxt;
  res_t                 cur_res_r, cur_res_nxt;
  count_t               cnt_r, cnt_nxt;

  logic                  out_valid_r, out_valid_nxt;
  count_t                out_cnt_r, out_cnt_nxt;
  logic [ORDER_BITS-1:0] out_ord_r, out_ord_nxt;
  logic                  out_err_r, out_err_nxt;

  res_t                 res1, res2;
  logic                 ok1, ok2, first_later, same;
  day_t                 stp_d;
  month_t               stp_m;
  logic [YEAR_BITS-1:0] stp_y;
  res_t                 stp_res;
  logic                 at_tgt;

  assign res1 = year_mod33(YEAR_MAX_BITS'(y1_r));
  assign res2 = year_mod33(YEAR_MAX_BITS'(y2_r));
  assign ok1  = date_ok(d1_r, m1_r, res1);
  assign ok2  = date_ok(d2_r, m2_r, res2);
  assign first_later = {y1_r, m1_r, d1_r} > {y2_r, m2_r, d2_r};
  assign same        = {y1_r, m1_r, d1_r} == {y2_r, m2_r, d2_r};
  assign at_tgt      = {cur_y_r, cur_m_r, cur_d_r} == {tgt_y_r, tgt_m_r, tgt_d_r};

  shd_step #(.YEAR_BITS(YEAR_BITS)) u_step (
    .cur_day   (cur_d_r),
    .cur_month (cur_m_r),
    .cur_year  (cur_y_r),
    .cur_res   (cur_res_r),
    .nxt_day   (stp_d),
    .nxt_month (stp_m),
    .nxt_year  (stp_y),
    .nxt_res   (stp_res)
  );

  always_comb begin
    state_nxt     = state_r;
    cur_d_nxt     = cur_d_r;
    cur_m_nxt     = cur_m_r;
    cur_y_nxt     = cur_y_r;
    cur_res_nxt   = cur_res_r;
    tgt_d_nxt     = tgt_d_r;
    tgt_m_nxt     = tgt_m_r;
    tgt_y_nxt     = tgt_y_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_cnt_nxt   = out_cnt_r;
    out_ord_nxt   = out_ord_r;
    out_err_nxt   = out_err_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!(ok1 && ok2) || same) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = '0;
          out_ord_nxt   = ORD_EQUAL;
          out_err_nxt   = !(ok1 && ok2);
          state_nxt     = S_IDLE;
        end else begin
          cnt_nxt     = count_t'(1);
          out_ord_nxt = first_later ? ORD_FIRST_LATER : ORD_FIRST_EARLIER;
          out_err_nxt = 1'b0;
          if (first_later) begin
            cur_d_nxt = d2_r; cur_m_nxt = m2_r; cur_y_nxt = y2_r; cur_res_nxt = res2;
            tgt_d_nxt = d1_r; tgt_m_nxt = m1_r; tgt_y_nxt = y1_r;
          end else begin
            cur_d_nxt = d1_r; cur_m_nxt = m1_r; cur_y_nxt = y1_r; cur_res_nxt = res1;
            tgt_d_nxt = d2_r; tgt_m_nxt = m2_r; tgt_y_nxt = y2_r;
          end
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (at_tgt) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = cnt_r;
          state_nxt     = S_IDLE;
        end else begin
          cur_d_nxt   = stp_d;
          cur_m_nxt   = stp_m;
          cur_y_nxt   = stp_y;
          cur_res_nxt = stp_res;
          cnt_nxt     = cnt_r + count_t'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input capture and walk datapath
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      d1_r <= in_first_day;
      m1_r <= in_first_month;
      y1_r <= in_first_year;
      d2_r <= in_second_day;
      m2_r <= in_second_month;
      y2_r <= in_second_year;
    end
    cur_d_r   <= cur_d_nxt;
    cur_m_r   <= cur_m_nxt;
    cur_y_r   <= cur_y_nxt;
    cur_res_r <= cur_res_nxt;
    tgt_d_r   <= tgt_d_nxt;
    tgt_m_r   <= tgt_m_nxt;
    tgt_y_r   <= tgt_y_nxt;
    cnt_r     <= cnt_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_ord_r <= out_ord_nxt;
    out_err_r <= out_err_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_day_count  = out_cnt_r;
  assign out_order      = out_ord_r;
  assign out_date_error = out_err_r;

endmodule

### dv/solar_hijri_day_difference_top_tb.sv
`timescale 1ns / 100ps
// testbench for solar_hijri_day_difference_top: directed and random date pairs, each transfer
// predicted by a small scoreboard that holds the expected count, order and error flag
// depends on shd_pkg and the design sources

module solar_hijri_day_difference_top_tb;
  import shd_pkg::*;

  localparam int YB           = YEAR_BITS_DEF;
  localparam int YEAR_TOP     = (1 << YB) - 1;
  localparam int STALL_LIMIT  = 6000000;
  localparam int RANDOM_ITEMS = 80;
  localparam int MAX_REPORTS  = 10;

  typedef logic [YB-1:0] year_t;

  typedef struct {
    day_t   first_day;
    month_t first_month;
    year_t  first_year;
    day_t   second_day;
    month_t second_month;
    year_t  second_year;
  } date_pair_t;

  typedef struct {
    count_t                day_count;
    logic [ORDER_BITS-1:0] order;
    logic                  date_error;
  } span_t;

  class day_diff_board;
    span_t spans_due[$];
    int    mismatches;

    function new();
      mismatches = 0;
    endfunction

    function bit leap_year(int unsigned y);
      int unsigned r;
      r = y % 33;
      return (r == 1) || (r == 5) || (r == 9) || (r == 13) || (r == 17) ||
             (r == 22) || (r == 26) || (r == 30);
    endfunction

    function int unsigned month_days(int unsigned m, int unsigned y);
      if (m < 7) return 31;
      if (m < 12) return 30;
      return leap_year(y) ? 30 : 29;
    endfunction

    function bit date_good(int unsigned d, int unsigned m, int unsigned y);
      if (m < 1 || m > 12 || d < 1) return 1'b0;
      return d <= month_days(m, y);
    endfunction

    // days since day zero of year zero
    function int unsigned day_number(int unsigned d, int unsigned m, int unsigned y);
      int unsigned leaps;
      int unsigned before_month;
      leaps = (y / 33) * 8;
      for (int unsigned k = 0; k < y % 33; k++)
        if (leap_year(k)) leaps++;
      before_month = (m <= 7) ? 31 * (m - 1) : 186 + 30 * (m - 7);
      return 365 * y + leaps + before_month + d;
    endfunction

    function void note_item(date_pair_t p);
      span_t       s;
      int unsigned a;
      int unsigned b;
      s.day_count  = '0;
      s.order      = ORD_EQUAL;
      s.date_error = 1'b0;
      if (!date_good(p.first_day, p.first_month, p.first_year) ||
          !date_good(p.second_day, p.second_month, p.second_year)) begin
        s.date_error = 1'b1;
      end else begin
        a = day_number(p.first_day, p.first_month, p.first_year);
        b = day_number(p.second_day, p.second_month, p.second_year);
        if (a > b) begin
          s.day_count = count_t'(a - b + 1);
          s.order     = ORD_FIRST_LATER;
        end else if (a < b) begin
          s.day_count = count_t'(b - a + 1);
          s.order     = ORD_FIRST_EARLIER;
        end
      end
      spans_due.push_back(s);
    endfunction

    function void check_result(count_t cnt, logic [ORDER_BITS-1:0] ord, logic err);
      span_t want;
      if (spans_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: count %0d order %0d error %0b", cnt, ord, err);
        return;
      end
      want = spans_due.pop_front();
      if (cnt !== want.day_count || ord !== want.order || err !== want.date_error) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: count %0d/%0d order %0d/%0d error %0b/%0b (expected/actual)",
                   want.day_count, cnt, want.order, ord, want.date_error, err);
      end
    endfunction
  endclass

  logic   clk             = 1'b0;
  logic   rst_n           = 1'b0;
  logic   start           = 1'b0;
  logic   busy;
  day_t   in_first_day    = '0;
  month_t in_first_month  = '0;
  year_t  in_first_year   = '0;
  day_t   in_second_day   = '0;
  month_t in_second_month = '0;
  year_t  in_second_year  = '0;
  logic                  out_valid;
  count_t                out_day_count;
  logic [ORDER_BITS-1:0] out_order;
  logic                  out_date_error;

  day_diff_board board;
  int            stall_cycles = 0;
  bit            steady       = 1'b0;

  solar_hijri_day_difference_top #(.YEAR_BITS(YB)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_first_day    (in_first_day),
    .in_first_month  (in_first_month),
    .in_first_year   (in_first_year),
    .in_second_day   (in_second_day),
    .in_second_month (in_second_month),
    .in_second_year  (in_second_year),
    .out_valid       (out_valid),
    .out_day_count   (out_day_count),
    .out_order       (out_order),
    .out_date_error  (out_date_error)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid)
      board.check_result(out_day_count, out_order, out_date_error);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic date_pair_t mk(int d1, int m1, int y1, int d2, int m2, int y2);
    date_pair_t p;
    p.first_day    = day_t'(d1);
    p.first_month  = month_t'(m1);
    p.first_year   = year_t'(y1);
    p.second_day   = day_t'(d2);
    p.second_month = month_t'(m2);
    p.second_year  = year_t'(y2);
    return p;
  endfunction

  function automatic void good_date(output day_t d, output month_t m);
    m = month_t'($urandom_range(1, 12));
    if (m < 7) d = day_t'($urandom_range(1, 31));
    else if (m < 12) d = day_t'($urandom_range(1, 30));
    else d = day_t'($urandom_range(1, 29 + $urandom_range(0, 1)));
  endfunction

  function automatic void bad_date(output day_t d, output month_t m);
    case ($urandom_range(0, 3))
      0: begin
        m = '0;
        d = day_t'($urandom_range(1, 31));
      end
      1: begin
        m = month_t'($urandom_range(13, 15));
        d = day_t'($urandom_range(1, 31));
      end
      2: begin
        m = month_t'($urandom_range(1, 12));
        d = '0;
      end
      default: begin
        m = month_t'($urandom_range(7, 12));
        d = day_t'(31);
      end
    endcase
  endfunction

  function automatic date_pair_t random_pair();
    date_pair_t p;
    int         roll;
    int         y1;
    int         y2;
    int         off;
    roll = $urandom_range(0, 99);
    y1   = $urandom_range(0, YEAR_TOP);
    if (roll < 45) off = 0;
    else if (roll < 93) off = $urandom_range(0, 3);
    else off = $urandom_range(4, 40);
    if ($urandom_range(0, 1)) off = -off;
    y2 = y1 + off;
    if (y2 < 0 || y2 > YEAR_TOP) y2 = y1 - off;
    good_date(p.first_day, p.first_month);
    good_date(p.second_day, p.second_month);
    if (roll < 4 || roll >= 8 && roll < 10) bad_date(p.first_day, p.first_month);
    if (roll >= 4 && roll < 10) bad_date(p.second_day, p.second_month);
    if (roll >= 10 && roll < 45 && $urandom_range(0, 3) == 0) p.second_month = p.first_month;
    if (roll >= 45 && roll < 50) begin
      y2             = y1;
      p.second_day   = p.first_day;
      p.second_month = p.first_month;
    end
    p.first_year  = year_t'(y1);
    p.second_year = year_t'(y2);
    return p;
  endfunction

  // called at a rising edge; returns at the edge that accepts the transfer
  task automatic send_pair(input date_pair_t p, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_first_day    <= p.first_day;
    in_first_month  <= p.first_month;
    in_first_year   <= p.first_year;
    in_second_day   <= p.second_day;
    in_second_month <= p.second_month;
    in_second_year  <= p.second_year;
    do @(posedge clk); while (busy);
    board.note_item(p);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (board.spans_due.size() != 0);
  endtask

  initial begin
    date_pair_t directed[$];
    board = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(mk(1, 1, 0, 1, 1, 0));
    directed.push_back(mk(29, 12, 4095, 29, 12, 4095));
    directed.push_back(mk(31, 6, 4095, 1, 7, 4095));
    directed.push_back(mk(1, 7, 4095, 31, 6, 4095));
    directed.push_back(mk(29, 12, 4094, 1, 1, 4095));
    directed.push_back(mk(30, 12, 1, 1, 1, 2));
    directed.push_back(mk(30, 12, 2, 1, 1, 2));
    directed.push_back(mk(1, 1, 22, 30, 12, 22));
    directed.push_back(mk(30, 12, 26, 30, 12, 30));
    directed.push_back(mk(30, 12, 5, 30, 12, 9));
    directed.push_back(mk(30, 12, 13, 29, 12, 17));
    directed.push_back(mk(30, 12, 63, 1, 1, 64));
    directed.push_back(mk(1, 1, 0, 30, 12, 1));
    directed.push_back(mk(1, 1, 4095, 29, 12, 4095));
    directed.push_back(mk(1, 0, 100, 1, 1, 100));
    directed.push_back(mk(1, 13, 100, 1, 1, 100));
    directed.push_back(mk(1, 1, 100, 15, 15, 100));
    directed.push_back(mk(0, 5, 100, 1, 1, 100));
    directed.push_back(mk(31, 7, 100, 1, 1, 100));
    directed.push_back(mk(31, 6, 100, 31, 11, 2048));
    directed.push_back(mk(31, 12, 2047, 0, 15, 2048));
    directed.push_back(mk(16, 8, 2047, 16, 8, 2048));
    directed.push_back(mk(31, 1, 3495, 29, 12, 4095));
    foreach (directed[i]) send_pair(directed[i], $urandom_range(0, 6));

    // sender holds off until the block has gone quiet
    drain();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 12 == 0) steady = ($urandom_range(0, 2) == 0);
      if (n == RANDOM_ITEMS / 2) drain();
      send_pair(random_pair(), steady ? 0 : $urandom_range(0, 6));
    end

    drain();
    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.spans_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
